/* hdl/bpbc_pkg.sv */
// shared types and constants for the bright pixel blob centroid block
// no dependencies
package bpbc_pkg;

    localparam int COORD_W   = 12;
    localparam int NUM_CELLS = 64;
    localparam int IDX_W     = $clog2(NUM_CELLS);
    localparam int USED_W    = $clog2(NUM_CELLS + 1);
    localparam int CNT_W     = 25;
    localparam int SUM_W     = COORD_W + CNT_W - 1;
    localparam int SQ_W      = 2 * COORD_W;
    localparam int D2_W      = SQ_W + 1;
    localparam int LEVEL_W   = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_AW    = 3;
    localparam int STEP_W    = $clog2(COORD_W);

    localparam logic [LEVEL_W-1:0] LEVEL_RESET   = LEVEL_W'(60);
    localparam logic [SQ_W-1:0]    JOIN_SQ_RESET = SQ_W'(1);
    localparam logic [SQ_W-1:0]    SKIP_SQ_RESET = SQ_W'(20 * 20);

    localparam logic [CFG_AW-1:0] CFG_BLUE  = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_GREEN = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_RED   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_JOIN  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_SKIP  = 3'd4;

    typedef enum logic [2:0] {
        ST_DIM  = 3'd0,
        ST_JOIN = 3'd1,
        ST_NEW  = 3'd2,
        ST_SKIP = 3'd3,
        ST_FULL = 3'd4
    } status_t;

    // pixel token moving down the cell row
    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] r;
        logic [COORD_W-1:0] c;
        logic               found;
        logic               near;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
    } tok_t;

    // centre update broadcast to the cells
    typedef struct packed {
        logic               en;
        logic [IDX_W-1:0]   idx;
        logic [COORD_W-1:0] crow;
        logic [COORD_W-1:0] ccol;
    } cell_wr_t;

    typedef struct packed {
        logic [SUM_W-1:0] rs;
        logic [SUM_W-1:0] cs;
        logic [CNT_W-1:0] cnt;
    } acc_t;

endpackage

/* hdl/bpbc_cell.sv */
// one cluster cell: holds a centre, tests the passing pixel token
// depends on bpbc_pkg
module bpbc_cell (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [bpbc_pkg::IDX_W-1:0]        cell_idx,
    input  logic [bpbc_pkg::USED_W-1:0]       used,
    input  logic [bpbc_pkg::SQ_W-1:0]         join_sq,
    input  logic [bpbc_pkg::SQ_W-1:0]         skip_sq,
    input  bpbc_pkg::cell_wr_t                wr,
    input  bpbc_pkg::tok_t                    tok_in,
    output bpbc_pkg::tok_t                    tok_out
);

    logic [bpbc_pkg::COORD_W-1:0] crow_reg;
    logic [bpbc_pkg::COORD_W-1:0] ccol_reg;
    bpbc_pkg::tok_t               tok_reg;
    bpbc_pkg::tok_t               tok_next;
    logic [bpbc_pkg::COORD_W-1:0] dr;
    logic [bpbc_pkg::COORD_W-1:0] dc;
    logic [bpbc_pkg::D2_W-1:0]    d2;
    logic                         active;

    assign active = {1'b0, cell_idx} < used;
    assign dr = (tok_in.r > crow_reg) ? tok_in.r - crow_reg : crow_reg - tok_in.r;
    assign dc = (tok_in.c > ccol_reg) ? tok_in.c - ccol_reg : ccol_reg - tok_in.c;
    assign d2 = bpbc_pkg::D2_W'(bpbc_pkg::SQ_W'(dr) * bpbc_pkg::SQ_W'(dr))
              + bpbc_pkg::D2_W'(bpbc_pkg::SQ_W'(dc) * bpbc_pkg::SQ_W'(dc));

    always_comb
    begin
        tok_next = tok_in;
        if (tok_in.valid && active && !tok_in.found)
        begin
            if (d2 <= {1'b0, join_sq})
            begin
                tok_next.found = 1'b1;
                tok_next.idx   = cell_idx;
                tok_next.crow  = crow_reg;
                tok_next.ccol  = ccol_reg;
            end
            else if (d2 < {1'b0, skip_sq})
            begin
                tok_next.near = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else
            tok_reg <= tok_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && wr.idx == cell_idx)
        begin
            crow_reg <= wr.crow;
            ccol_reg <= wr.ccol;
        end
    end

    assign tok_out = tok_reg;

endmodule

/* hdl/bpbc_div.sv */
// restoring divider, one quotient bit per cycle, quotient fits a coordinate
// depends on bpbc_pkg
module bpbc_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [bpbc_pkg::SUM_W-1:0]    numer,
    input  logic [bpbc_pkg::CNT_W-1:0]    denom,
    output logic                          done,
    output logic [bpbc_pkg::COORD_W-1:0]  quot
);

    logic [bpbc_pkg::SUM_W-1:0]   rem_reg;
    logic [bpbc_pkg::SUM_W-1:0]   dsh_reg;
    logic [bpbc_pkg::COORD_W-1:0] q_reg;
    logic [bpbc_pkg::STEP_W-1:0]  step_reg;
    logic                         busy_reg;
    logic                         done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= bpbc_pkg::STEP_W'(bpbc_pkg::COORD_W - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= numer;
            dsh_reg <= {denom, (bpbc_pkg::COORD_W - 1)'(0)};
            q_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (rem_reg >= dsh_reg)
            begin
                rem_reg <= rem_reg - dsh_reg;
                q_reg   <= {q_reg[bpbc_pkg::COORD_W-2:0], 1'b1};
            end
            else
            begin
                q_reg   <= {q_reg[bpbc_pkg::COORD_W-2:0], 1'b0};
            end
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* hdl/bright_pixel_blob_centroids.sv */
// bright pixel blob clustering with integer centroids
// order: a dim pixel goes through the result registers to the output register;
// a bright pixel crosses the cell row; a join adds an accumulator read and a divide
// throughput: one transaction at a time, set by the 64-cell row and the divider
// reset: async active low, clears config to defaults and the cluster count;
// centre cells and accumulator memory hold no reset and are read only once written
module bright_pixel_blob_centroids (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [bpbc_pkg::CFG_AW-1:0]         cfg_addr,
    input  logic [bpbc_pkg::CFG_W-1:0]          cfg_wdata,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [11:0]                         row,
    input  logic [11:0]                         col,
    input  logic [7:0]                          blue,
    input  logic [7:0]                          green,
    input  logic [7:0]                          red,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [2:0]                          status,
    output logic [5:0]                          cluster_index,
    output logic [11:0]                         centre_row,
    output logic [11:0]                         centre_col,
    output logic [24:0]                         member_count
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LOAD,
        S_DIV,
        S_FIN
    } state_t;

    state_t state_reg, state_next;

    // config registers
    logic [bpbc_pkg::LEVEL_W-1:0] blue_lvl_reg, blue_lvl_next;
    logic [bpbc_pkg::LEVEL_W-1:0] green_lvl_reg, green_lvl_next;
    logic [bpbc_pkg::LEVEL_W-1:0] red_lvl_reg, red_lvl_next;
    logic [bpbc_pkg::SQ_W-1:0]    join_sq_reg, join_sq_next;
    logic [bpbc_pkg::SQ_W-1:0]    skip_sq_reg, skip_sq_next;

    logic [bpbc_pkg::USED_W-1:0]  used_reg, used_next;

    // current pixel and pending result
    logic [bpbc_pkg::COORD_W-1:0] pr_reg, pr_next;
    logic [bpbc_pkg::COORD_W-1:0] pc_reg, pc_next;
    bpbc_pkg::status_t            res_st_reg, res_st_next;
    logic [bpbc_pkg::IDX_W-1:0]   res_idx_reg, res_idx_next;
    logic [bpbc_pkg::COORD_W-1:0] res_crow_reg, res_crow_next;
    logic [bpbc_pkg::COORD_W-1:0] res_ccol_reg, res_ccol_next;
    logic [bpbc_pkg::CNT_W-1:0]   res_cnt_reg, res_cnt_next;

    // output register
    logic                         out_valid_reg, out_valid_next;
    bpbc_pkg::status_t            out_st_reg, out_st_next;
    logic [bpbc_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic [bpbc_pkg::COORD_W-1:0] out_crow_reg, out_crow_next;
    logic [bpbc_pkg::COORD_W-1:0] out_ccol_reg, out_ccol_next;
    logic [bpbc_pkg::CNT_W-1:0]   out_cnt_reg, out_cnt_next;

    // accumulator memory: row sum, col sum and count per cluster
    bpbc_pkg::acc_t               acc_mem [bpbc_pkg::NUM_CELLS];
    bpbc_pkg::acc_t               acc_rd_reg;
    bpbc_pkg::acc_t               acc_wdata;
    logic [bpbc_pkg::IDX_W-1:0]   acc_waddr;
    logic                         acc_we;

    // cell row
    bpbc_pkg::tok_t               chain [bpbc_pkg::NUM_CELLS+1];
    bpbc_pkg::tok_t               inj;
    bpbc_pkg::tok_t               tail;
    bpbc_pkg::cell_wr_t           cwr;

    // dividers
    logic                         div_start;
    logic [bpbc_pkg::SUM_W-1:0]   div_rnum;
    logic [bpbc_pkg::SUM_W-1:0]   div_cnum;
    logic [bpbc_pkg::CNT_W-1:0]   div_den;
    logic                         div_rdone;
    logic                         div_cdone;
    logic [bpbc_pkg::COORD_W-1:0] div_rq;
    logic [bpbc_pkg::COORD_W-1:0] div_cq;

    logic                         bright;
    logic                         out_free;
    bpbc_pkg::acc_t               acc_upd;

    assign chain[0] = inj;
    assign tail     = chain[bpbc_pkg::NUM_CELLS];

    genvar gi;
    generate
        for (gi = 0; gi < bpbc_pkg::NUM_CELLS; gi++)
        begin : g_cell
            bpbc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .cell_idx (bpbc_pkg::IDX_W'(gi)),
                .used     (used_reg),
                .join_sq  (join_sq_reg),
                .skip_sq  (skip_sq_reg),
                .wr       (cwr),
                .tok_in   (chain[gi]),
                .tok_out  (chain[gi+1])
            );
        end
    endgenerate

    bpbc_div u_div_row (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_rnum),
        .denom (div_den),
        .done  (div_rdone),
        .quot  (div_rq)
    );

    bpbc_div u_div_col (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .numer (div_cnum),
        .denom (div_den),
        .done  (div_cdone),
        .quot  (div_cq)
    );

    assign bright = (blue > blue_lvl_reg) && (green > green_lvl_reg) && (red > red_lvl_reg);
    assign out_free = !out_valid_reg || out_ready;

    // joined cluster after adding this pixel
    assign acc_upd.rs  = acc_rd_reg.rs + bpbc_pkg::SUM_W'(pr_reg);
    assign acc_upd.cs  = acc_rd_reg.cs + bpbc_pkg::SUM_W'(pc_reg);
    assign acc_upd.cnt = acc_rd_reg.cnt + 1'b1;

    assign div_rnum = acc_upd.rs;
    assign div_cnum = acc_upd.cs;
    assign div_den  = acc_upd.cnt;

    always_comb
    begin
        state_next     = state_reg;
        blue_lvl_next  = blue_lvl_reg;
        green_lvl_next = green_lvl_reg;
        red_lvl_next   = red_lvl_reg;
        join_sq_next   = join_sq_reg;
        skip_sq_next   = skip_sq_reg;
        used_next      = used_reg;
        pr_next        = pr_reg;
        pc_next        = pc_reg;
        res_st_next    = res_st_reg;
        res_idx_next   = res_idx_reg;
        res_crow_next  = res_crow_reg;
        res_ccol_next  = res_ccol_reg;
        res_cnt_next   = res_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_st_next    = out_st_reg;
        out_idx_next   = out_idx_reg;
        out_crow_next  = out_crow_reg;
        out_ccol_next  = out_ccol_reg;
        out_cnt_next   = out_cnt_reg;
        inj            = '0;
        cwr            = '0;
        acc_we         = 1'b0;
        acc_waddr      = tail.idx;
        acc_wdata      = acc_upd;
        div_start      = 1'b0;

        // config writes, taken only while idle by contract
        if (cfg_we)
        begin
            unique case (cfg_addr)
                bpbc_pkg::CFG_BLUE:  blue_lvl_next  = cfg_wdata[bpbc_pkg::LEVEL_W-1:0];
                bpbc_pkg::CFG_GREEN: green_lvl_next = cfg_wdata[bpbc_pkg::LEVEL_W-1:0];
                bpbc_pkg::CFG_RED:   red_lvl_next   = cfg_wdata[bpbc_pkg::LEVEL_W-1:0];
                bpbc_pkg::CFG_JOIN:  join_sq_next   = cfg_wdata * cfg_wdata;
                bpbc_pkg::CFG_SKIP:  skip_sq_next   = cfg_wdata * cfg_wdata;
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pr_next = row;
                    pc_next = col;
                    if (bright)
                    begin
                        // launch the token into the cell row
                        inj.valid  = 1'b1;
                        inj.r      = row;
                        inj.c      = col;
                        state_next = S_SCAN;
                    end
                    else
                    begin
                        res_st_next   = bpbc_pkg::ST_DIM;
                        res_idx_next  = '0;
                        res_crow_next = '0;
                        res_ccol_next = '0;
                        res_cnt_next  = '0;
                        state_next    = S_FIN;
                    end
                end
            end
            S_SCAN:
            begin
                if (tail.valid)
                begin
                    res_idx_next  = '0;
                    res_crow_next = '0;
                    res_ccol_next = '0;
                    res_cnt_next  = '0;
                    if (tail.found)
                    begin
                        // accumulator read issued this edge
                        res_st_next   = bpbc_pkg::ST_JOIN;
                        res_idx_next  = tail.idx;
                        res_crow_next = tail.crow;
                        res_ccol_next = tail.ccol;
                        state_next    = S_LOAD;
                    end
                    else if (tail.near)
                    begin
                        res_st_next = bpbc_pkg::ST_SKIP;
                        state_next  = S_FIN;
                    end
                    else if (used_reg == bpbc_pkg::USED_W'(bpbc_pkg::NUM_CELLS))
                    begin
                        res_st_next = bpbc_pkg::ST_FULL;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        // open a new cluster at the next free entry
                        acc_we        = 1'b1;
                        acc_waddr     = used_reg[bpbc_pkg::IDX_W-1:0];
                        acc_wdata.rs  = bpbc_pkg::SUM_W'(pr_reg);
                        acc_wdata.cs  = bpbc_pkg::SUM_W'(pc_reg);
                        acc_wdata.cnt = bpbc_pkg::CNT_W'(1);
                        cwr.en        = 1'b1;
                        cwr.idx       = used_reg[bpbc_pkg::IDX_W-1:0];
                        cwr.crow      = pr_reg;
                        cwr.ccol      = pc_reg;
                        used_next     = used_reg + 1'b1;
                        res_st_next   = bpbc_pkg::ST_NEW;
                        res_idx_next  = used_reg[bpbc_pkg::IDX_W-1:0];
                        res_crow_next = pr_reg;
                        res_ccol_next = pc_reg;
                        res_cnt_next  = bpbc_pkg::CNT_W'(1);
                        state_next    = S_FIN;
                    end
                end
            end
            S_LOAD:
            begin
                if (acc_rd_reg.cnt[bpbc_pkg::CNT_W-1])
                begin
                    // count at its cap: cluster frozen
                    res_cnt_next = acc_rd_reg.cnt;
                    state_next   = S_FIN;
                end
                else
                begin
                    acc_we       = 1'b1;
                    acc_waddr    = res_idx_reg;
                    res_cnt_next = acc_upd.cnt;
                    div_start    = 1'b1;
                    state_next   = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_rdone)
                begin
                    cwr.en        = 1'b1;
                    cwr.idx       = res_idx_reg;
                    cwr.crow      = div_rq;
                    cwr.ccol      = div_cq;
                    res_crow_next = div_rq;
                    res_ccol_next = div_cq;
                    state_next    = S_FIN;
                end
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_st_next    = res_st_reg;
                    out_idx_next   = res_idx_reg;
                    out_crow_next  = res_crow_reg;
                    out_ccol_next  = res_ccol_reg;
                    out_cnt_next   = res_cnt_reg;
                    state_next     = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            blue_lvl_reg  <= bpbc_pkg::LEVEL_RESET;
            green_lvl_reg <= bpbc_pkg::LEVEL_RESET;
            red_lvl_reg   <= bpbc_pkg::LEVEL_RESET;
            join_sq_reg   <= bpbc_pkg::JOIN_SQ_RESET;
            skip_sq_reg   <= bpbc_pkg::SKIP_SQ_RESET;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            blue_lvl_reg  <= blue_lvl_next;
            green_lvl_reg <= green_lvl_next;
            red_lvl_reg   <= red_lvl_next;
            join_sq_reg   <= join_sq_next;
            skip_sq_reg   <= skip_sq_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pr_reg       <= pr_next;
        pc_reg       <= pc_next;
        res_st_reg   <= res_st_next;
        res_idx_reg  <= res_idx_next;
        res_crow_reg <= res_crow_next;
        res_ccol_reg <= res_ccol_next;
        res_cnt_reg  <= res_cnt_next;
        out_st_reg   <= out_st_next;
        out_idx_reg  <= out_idx_next;
        out_crow_reg <= out_crow_next;
        out_ccol_reg <= out_ccol_next;
        out_cnt_reg  <= out_cnt_next;
    end

    // accumulator memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (acc_we)
            acc_mem[acc_waddr] <= acc_wdata;
        acc_rd_reg <= acc_mem[tail.idx];
    end

    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_st_reg;
    assign cluster_index = out_idx_reg;
    assign centre_row    = out_crow_reg;
    assign centre_col    = out_ccol_reg;
    assign member_count  = out_cnt_reg;

`ifndef NO_ASSERTIONS
    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= bpbc_pkg::USED_W'(bpbc_pkg::NUM_CELLS))
        else $error("cluster count beyond table size");

    a_tail_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        tail.valid |-> state_reg == S_SCAN)
        else $error("token left the cell row outside a scan");

    a_div_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rdone |-> (state_reg == S_DIV && div_cdone))
        else $error("divider finished outside divide state");

    a_dim_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_st_reg != bpbc_pkg::ST_JOIN && out_st_reg != bpbc_pkg::ST_NEW)
        |-> (out_cnt_reg == '0 && out_idx_reg == '0))
        else $error("non-cluster result carries cluster fields");

    a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (used_reg != $past(used_reg)) |-> ($past(state_reg) == S_SCAN))
        else $error("cluster count changed outside scan decision");
`endif

endmodule
